FILE: hw/rtl/ptdw_pkg.sv
// ----------------------------------------------------------------------------
// ptdw_pkg
// Types and constants shared by the PWM tone divider and wrap calculation.
// ----------------------------------------------------------------------------
`default_nettype none

package ptdw_pkg;

   localparam int CLOCK_W   = 28;
   localparam int VOLUME_W  = 7;
   localparam int TONE_W    = 20;
   localparam int DIVIDER_W = 8;
   localparam int OUT_W     = 16;
   localparam int PROD_W    = CLOCK_W + VOLUME_W;
   localparam int CNT_W     = 6;
   localparam int INDEX_W   = 2;

   localparam logic [CLOCK_W-1:0]  CLOCK_RESET  = 28'd125000000;
   localparam logic [VOLUME_W-1:0] VOLUME_RESET = 7'd50;
   localparam logic [VOLUME_W-1:0] PCT_MAX      = 7'd100;
   localparam logic [CLOCK_W-1:0]  PERIOD_MIN   = 28'd2;

   localparam logic [INDEX_W-1:0] REG_CLOCK_HZ       = 2'd0;
   localparam logic [INDEX_W-1:0] REG_VOLUME_PERCENT = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_CLK,
      ST_PREP,
      ST_DIV_DIV,
      ST_CLAMP,
      ST_MUL,
      ST_DIV_PCT,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

FILE: hw/rtl/pwm_tone_divider_wrap_calc.sv
// ----------------------------------------------------------------------------
// pwm_tone_divider_wrap_calc
// Turns a tone frequency into PWM divider, counter top and compare level
// using one bit-serial restoring divider shared by three passes.
// ----------------------------------------------------------------------------
//  channel  dir  ports                                   beat
//  req      in   req_valid req_stall req_tone_hz         one tone request
//  rsp      out  rsp_valid rsp_stall rsp_enabled ...     one pwm setting
//  csr      in   csr_we csr_index csr_wdata              register write
//
//  a nonzero tone runs three divider passes in order: clock over tone, the
//  period over the divider and the level over 100, with setup states between
//  a zero tone skips the divider passes and goes straight to the finish state
//  the serial divider handles one beat at a time; req_stall is high while busy
//  a finished result waits in the output register while rsp_stall is high
//  synchronous reset loads the clock and volume reset values
// ----------------------------------------------------------------------------
`default_nettype none

module pwm_tone_divider_wrap_calc #(
   parameter int MAX_DIVIDER = 255,
   parameter int PERIOD_BITS = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,

   input  wire logic                            req_valid,
   output      logic                            req_stall,
   input  wire logic [ptdw_pkg::TONE_W-1:0]     req_tone_hz,

   output      logic                            rsp_valid,
   input  wire logic                            rsp_stall,
   output      logic                            rsp_enabled,
   output      logic [ptdw_pkg::DIVIDER_W-1:0]  rsp_clock_divider,
   output      logic [ptdw_pkg::OUT_W-1:0]      rsp_counter_top,
   output      logic [ptdw_pkg::OUT_W-1:0]      rsp_compare_level,

   input  wire logic                            csr_we,
   input  wire logic [ptdw_pkg::INDEX_W-1:0]    csr_index,
   input  wire logic [ptdw_pkg::CLOCK_W-1:0]    csr_wdata
);
   import ptdw_pkg::*;

   localparam logic [32:0] PERIOD_LIMIT = (33'd1 << PERIOD_BITS) - 33'd1;

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [TONE_W-1:0]      dsr_ff, dsr_in;
   logic [TONE_W-1:0]      rem_ff, rem_in;
   logic [PROD_W-1:0]      quo_ff, quo_in;
   logic [DIVIDER_W-1:0]   div_ff, div_in;
   logic [CLOCK_W-1:0]     period_ff, period_in;
   logic [OUT_W-1:0]       top_ff, top_in;
   logic                   en_ff, en_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_en_ff, rsp_en_in;
   logic [DIVIDER_W-1:0]   rsp_div_ff, rsp_div_in;
   logic [OUT_W-1:0]       rsp_top_ff, rsp_top_in;
   logic [OUT_W-1:0]       rsp_lvl_ff, rsp_lvl_in;

   logic [CLOCK_W-1:0]     clock_hz_ff, clock_hz_in;
   logic [VOLUME_W-1:0]    volume_ff, volume_in;

   logic [TONE_W:0]        partial;
   logic [TONE_W:0]        diff;
   logic                   fits;
   logic [TONE_W-1:0]      rem_step;
   logic [PROD_W-1:0]      quo_step;
   logic [CLOCK_W-1:0]     q0;
   logic [CLOCK_W-1:0]     q0_hi;
   logic [DIVIDER_W-1:0]   div_calc;
   logic [CLOCK_W-1:0]     period_hi;
   logic [CLOCK_W-1:0]     period_clamp;
   logic [CLOCK_W-1:0]     period_dec;
   logic [PROD_W-1:0]      product;
   logic                   out_free;

   // divider step
   assign partial  = {rem_ff, quo_ff[PROD_W-1]};
   assign fits     = partial >= {1'b0, dsr_ff};
   assign diff     = partial - {1'b0, dsr_ff};
   assign rem_step = fits ? diff[TONE_W-1:0] : partial[TONE_W-1:0];
   assign quo_step = {quo_ff[PROD_W-2:0], fits};

   // divider choice: smallest d with (clock/tone)/d below 2^PERIOD_BITS, capped at MAX_DIVIDER
   assign q0    = quo_ff[CLOCK_W-1:0];
   assign q0_hi = q0 >> PERIOD_BITS;
   assign div_calc = (q0_hi >= CLOCK_W'(MAX_DIVIDER)) ? DIVIDER_W'(MAX_DIVIDER)
                                                      : q0_hi[DIVIDER_W-1:0] + 1'b1;

   // period clamp
   assign period_hi    = (33'(q0) > PERIOD_LIMIT) ? PERIOD_LIMIT[CLOCK_W-1:0] : q0;
   assign period_clamp = (period_hi < PERIOD_MIN) ? PERIOD_MIN : period_hi;
   assign period_dec   = period_clamp - 1'b1;

   assign product  = PROD_W'(period_ff) * PROD_W'(volume_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      dsr_in       = dsr_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      div_in       = div_ff;
      period_in    = period_ff;
      top_in       = top_ff;
      en_in        = en_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_en_in    = rsp_en_ff;
      rsp_div_in   = rsp_div_ff;
      rsp_top_in   = rsp_top_ff;
      rsp_lvl_in   = rsp_lvl_ff;
      clock_hz_in  = clock_hz_ff;
      volume_in    = volume_ff;
      req_stall    = state_ff != ST_IDLE;

      if (csr_we) begin
         unique case (csr_index)
            REG_CLOCK_HZ: begin
               clock_hz_in = csr_wdata;
            end
            REG_VOLUME_PERCENT: begin
               volume_in = (csr_wdata[VOLUME_W-1:0] > PCT_MAX) ? PCT_MAX
                                                              : csr_wdata[VOLUME_W-1:0];
            end
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               rem_in = '0;
               if (req_tone_hz == '0) begin
                  en_in    = 1'b0;
                  div_in   = DIVIDER_W'(1);
                  top_in   = '0;
                  quo_in   = '0;
                  state_in = ST_FINISH;
               end else begin
                  en_in    = 1'b1;
                  dsr_in   = req_tone_hz;
                  quo_in   = {clock_hz_ff, {(PROD_W-CLOCK_W){1'b0}}};
                  cnt_in   = CNT_W'(CLOCK_W - 1);
                  state_in = ST_DIV_CLK;
               end
            end
         end
         ST_DIV_CLK, ST_DIV_DIV, ST_DIV_PCT: begin
            rem_in = rem_step;
            quo_in = quo_step;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               unique case (state_ff)
                  ST_DIV_CLK: state_in = ST_PREP;
                  ST_DIV_DIV: state_in = ST_CLAMP;
                  default:    state_in = ST_FINISH;
               endcase
            end
         end
         ST_PREP: begin
            div_in   = div_calc;
            dsr_in   = TONE_W'(div_calc);
            rem_in   = '0;
            quo_in   = {q0, {(PROD_W-CLOCK_W){1'b0}}};
            cnt_in   = CNT_W'(CLOCK_W - 1);
            state_in = ST_DIV_DIV;
         end
         ST_CLAMP: begin
            period_in = period_clamp;
            top_in    = period_dec[OUT_W-1:0];
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            quo_in   = product;
            dsr_in   = TONE_W'(PCT_MAX);
            rem_in   = '0;
            cnt_in   = CNT_W'(PROD_W - 1);
            state_in = ST_DIV_PCT;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_en_in    = en_ff;
               rsp_div_in   = div_ff;
               rsp_top_in   = top_ff;
               rsp_lvl_in   = quo_ff[OUT_W-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         clock_hz_ff  <= CLOCK_RESET;
         volume_ff    <= VOLUME_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         clock_hz_ff  <= clock_hz_in;
         volume_ff    <= volume_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      dsr_ff     <= dsr_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      div_ff     <= div_in;
      period_ff  <= period_in;
      top_ff     <= top_in;
      en_ff      <= en_in;
      rsp_en_ff  <= rsp_en_in;
      rsp_div_ff <= rsp_div_in;
      rsp_top_ff <= rsp_top_in;
      rsp_lvl_ff <= rsp_lvl_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_enabled       = rsp_en_ff;
   assign rsp_clock_divider = rsp_div_ff;
   assign rsp_counter_top   = rsp_top_ff;
   assign rsp_compare_level = rsp_lvl_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != ST_IDLE))
      else $error("accepted beat did not start work");

   a_silence: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_enabled) |->
      (rsp_clock_divider == DIVIDER_W'(1) && rsp_counter_top == '0 &&
       rsp_compare_level == '0))
      else $error("silent result carries settings");

   a_enabled_div: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_enabled) |-> (rsp_clock_divider != '0))
      else $error("zero clock divider on running tone");

   a_volume_range: assert property (@(posedge clock) disable iff (reset)
      volume_ff <= PCT_MAX)
      else $error("volume above limit");

endmodule

`default_nettype wire

FILE: verif/tb_pwm_tone_divider_wrap_calc.sv
// ----------------------------------------------------------------------------
// tb_pwm_tone_divider_wrap_calc
// Drives tone requests into the PWM divider and wrap calculation and checks
// every returned setting in order against an in-bench prediction. A table of
// directed beats covers silence, register extremes, volume saturation and
// ignored register indexes. Random phases follow, each with new clock and
// volume settings and, in all but one steady phase, random idling on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_pwm_tone_divider_wrap_calc;
   import ptdw_pkg::*;

   localparam logic [INDEX_W-1:0] REG_SPARE_2 = 2'd2;
   localparam logic [INDEX_W-1:0] REG_SPARE_3 = 2'd3;
   localparam int                 DIV_LIMIT   = 255;
   localparam longint unsigned    PERIOD_TOP  = 64'd65535;
   localparam longint unsigned    PERIOD_LOW  = 64'd2;
   localparam longint unsigned    PCT_SCALE   = 64'd100;
   localparam logic [CLOCK_W-1:0] CLOCK_FULL  = 28'hFFFFFFF;
   localparam logic [TONE_W-1:0]  TONE_FULL   = 20'hFFFFF;
   localparam int                 PHASES      = 8;
   localparam int                 PHASE_BEATS = 180;

   typedef struct packed {
      logic                 enabled;
      logic [DIVIDER_W-1:0] divider;
      logic [OUT_W-1:0]     top;
      logic [OUT_W-1:0]     level;
   } pwm_setting_type;

   typedef enum logic {ROW_TONE, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type         kind;
      logic [INDEX_W-1:0]   index;
      logic [CLOCK_W-1:0]   data;
      logic [TONE_W-1:0]    tone;
      bit                   typed;
      pwm_setting_type      want;
   } stim_row_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [TONE_W-1:0]    req_tone_hz;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic                 rsp_enabled;
   logic [DIVIDER_W-1:0] rsp_clock_divider;
   logic [OUT_W-1:0]     rsp_counter_top;
   logic [OUT_W-1:0]     rsp_compare_level;
   logic                 csr_we;
   logic [INDEX_W-1:0]   csr_index;
   logic [CLOCK_W-1:0]   csr_wdata;

   logic [CLOCK_W-1:0]   model_clock_hz;
   logic [VOLUME_W-1:0]  model_volume;
   pwm_setting_type      pending_settings[$];
   stim_row_type         directed_plan[$];
   int                   mismatch_count = 0;
   bit                   steady = 1'b0;
   pwm_setting_type      want_setting;
   pwm_setting_type      got_setting;

   pwm_tone_divider_wrap_calc u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_tone_hz       (req_tone_hz),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_enabled       (rsp_enabled),
      .rsp_clock_divider (rsp_clock_divider),
      .rsp_counter_top   (rsp_counter_top),
      .rsp_compare_level (rsp_compare_level),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #2 clock = ~clock;

   initial begin
      #6000000;
      $display("tb_pwm_tone_divider_wrap_calc NOT OK");
      $finish;
   end

   function automatic pwm_setting_type compute_setting(input logic [TONE_W-1:0] tone);
      longint unsigned clk;
      longint unsigned freq;
      longint unsigned div;
      longint unsigned period;
      longint unsigned level;
      pwm_setting_type s;
      clk  = model_clock_hz;
      freq = tone;
      if (freq == 0) begin
         s.enabled = 1'b0;
         s.divider = 8'd1;
         s.top     = '0;
         s.level   = '0;
         return s;
      end
      div    = 1;
      period = clk / freq;
      while (period > PERIOD_TOP && div < DIV_LIMIT) begin
         div++;
         period = clk / (freq * div);
      end
      if (period > PERIOD_TOP) period = PERIOD_TOP;
      if (period < PERIOD_LOW) period = PERIOD_LOW;
      level     = (period * longint'(model_volume)) / PCT_SCALE;
      s.enabled = 1'b1;
      s.divider = div[DIVIDER_W-1:0];
      s.top     = OUT_W'(period - 1);
      s.level   = level[OUT_W-1:0];
      return s;
   endfunction

   function automatic pwm_setting_type setting(input logic en, input int div, input int top,
                                               input int level);
      pwm_setting_type s;
      s.enabled = en;
      s.divider = DIVIDER_W'(div);
      s.top     = OUT_W'(top);
      s.level   = OUT_W'(level);
      return s;
   endfunction

   function automatic stim_row_type tone_row(input logic [TONE_W-1:0] tone);
      stim_row_type r;
      r.kind  = ROW_TONE;
      r.index = '0;
      r.data  = '0;
      r.tone  = tone;
      r.typed = 1'b0;
      r.want  = '0;
      return r;
   endfunction

   function automatic stim_row_type typed_row(input logic [TONE_W-1:0] tone,
                                              input pwm_setting_type want);
      stim_row_type r;
      r       = tone_row(tone);
      r.typed = 1'b1;
      r.want  = want;
      return r;
   endfunction

   function automatic stim_row_type csr_row(input logic [INDEX_W-1:0] index,
                                            input logic [CLOCK_W-1:0] data);
      stim_row_type r;
      r       = tone_row('0);
      r.kind  = ROW_CSR;
      r.index = index;
      r.data  = data;
      return r;
   endfunction

   function automatic logic [TONE_W-1:0] pick_tone();
      case ($urandom_range(0, 19))
         0:             return '0;
         1:             return TONE_FULL;
         2, 3:          return TONE_W'($urandom_range(1, 255));
         4, 5, 6, 7, 8: return TONE_W'($urandom_range(20, 20000));
         9, 10, 11:     return TONE_W'($urandom_range(1, 4000));
         default:       return TONE_W'($urandom);
      endcase
   endfunction

   function automatic logic [CLOCK_W-1:0] pick_clock();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return CLOCK_W'(1);
         2:       return CLOCK_FULL;
         3:       return CLOCK_RESET;
         4, 5, 6: return CLOCK_W'($urandom);
         default: return CLOCK_W'($urandom_range(1000, 50000000));
      endcase
   endfunction

   task automatic report_failure(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%s", what);
   endtask

   task automatic write_reg(input logic [INDEX_W-1:0] index, input logic [CLOCK_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      case (index)
         REG_CLOCK_HZ:       model_clock_hz = data;
         REG_VOLUME_PERCENT: model_volume = (data[VOLUME_W-1:0] > PCT_MAX) ?
                                            PCT_MAX : data[VOLUME_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // called at a falling edge, returns at a falling edge with valid left high
   task automatic send_tone(input logic [TONE_W-1:0] tone, input bit typed,
                            input pwm_setting_type want);
      while (!steady && $urandom_range(0, 99) < 33) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_tone_hz <= tone;
      do @(posedge clock); while (req_stall);
      pending_settings.push_back(typed ? want : compute_setting(tone));
      @(negedge clock);
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (pending_settings.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_stall <= !steady && ($urandom_range(0, 99) < 33);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got_setting.enabled = rsp_enabled;
         got_setting.divider = rsp_clock_divider;
         got_setting.top     = rsp_counter_top;
         got_setting.level   = rsp_compare_level;
         if (pending_settings.size() == 0) begin
            report_failure($sformatf("unexpected beat: en %0d div %0d top %0d level %0d",
               got_setting.enabled, got_setting.divider, got_setting.top,
               got_setting.level));
         end else begin
            want_setting = pending_settings.pop_front();
            if (got_setting.enabled != want_setting.enabled ||
                got_setting.divider != want_setting.divider ||
                got_setting.top != want_setting.top ||
                got_setting.level != want_setting.level) begin
               report_failure($sformatf(
                  "mismatch: expected en %0d div %0d top %0d level %0d, %s",
                  want_setting.enabled, want_setting.divider, want_setting.top,
                  want_setting.level,
                  $sformatf("got en %0d div %0d top %0d level %0d",
                     got_setting.enabled, got_setting.divider,
                     got_setting.top, got_setting.level)));
            end
         end
      end
   end

   initial begin
      stim_row_type row;
      int           waited;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_tone_hz    = '0;
      rsp_stall      = 1'b0;
      csr_we         = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      model_clock_hz = CLOCK_RESET;
      model_volume   = VOLUME_RESET;

      // reset values: 125 MHz, half volume
      directed_plan.push_back(typed_row('0, setting(1'b0, 1, 0, 0)));
      directed_plan.push_back(typed_row(20'd1, setting(1'b1, 255, 65534, 32767)));
      directed_plan.push_back(tone_row(TONE_FULL));
      directed_plan.push_back(tone_row(20'd2000));
      directed_plan.push_back(tone_row(20'd1000));
      directed_plan.push_back(tone_row(20'd1907));
      directed_plan.push_back(tone_row(20'd1908));
      directed_plan.push_back(tone_row(20'd8));
      // volume above full scale saturates
      directed_plan.push_back(csr_row(REG_VOLUME_PERCENT, 28'd127));
      directed_plan.push_back(typed_row(20'd1, setting(1'b1, 255, 65534, 65535)));
      directed_plan.push_back(csr_row(REG_VOLUME_PERCENT, 28'd0));
      directed_plan.push_back(typed_row(20'd1, setting(1'b1, 255, 65534, 0)));
      directed_plan.push_back(tone_row(20'd440));
      // zero clock clamps the period up
      directed_plan.push_back(csr_row(REG_CLOCK_HZ, 28'd0));
      directed_plan.push_back(typed_row(20'd440, setting(1'b1, 1, 1, 0)));
      directed_plan.push_back(csr_row(REG_VOLUME_PERCENT, 28'd100));
      directed_plan.push_back(typed_row(TONE_FULL, setting(1'b1, 1, 1, 2)));
      directed_plan.push_back(typed_row('0, setting(1'b0, 1, 0, 0)));
      directed_plan.push_back(csr_row(REG_CLOCK_HZ, 28'd1));
      directed_plan.push_back(typed_row(20'd1, setting(1'b1, 1, 1, 2)));
      directed_plan.push_back(csr_row(REG_CLOCK_HZ, CLOCK_FULL));
      directed_plan.push_back(typed_row(20'd1, setting(1'b1, 255, 65534, 65535)));
      directed_plan.push_back(tone_row(TONE_FULL));
      // writes to unused indexes are dropped
      directed_plan.push_back(csr_row(REG_SPARE_2, 28'h5555555));
      directed_plan.push_back(csr_row(REG_SPARE_3, 28'hAAAAAAA));
      directed_plan.push_back(tone_row(20'd4096));
      directed_plan.push_back(csr_row(REG_CLOCK_HZ, 28'd1000));
      directed_plan.push_back(typed_row(20'd1000, setting(1'b1, 1, 1, 2)));

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         row = directed_plan[i];
         if (row.kind == ROW_CSR) begin
            drain_pipeline();
            write_reg(row.index, row.data);
         end else begin
            send_tone(row.tone, row.typed, row.want);
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         drain_pipeline();
         steady = (phase == 3);
         write_reg(REG_CLOCK_HZ, pick_clock());
         write_reg(REG_VOLUME_PERCENT,
                   CLOCK_W'(($urandom & 32'hFFFFFF80) | $urandom_range(0, 127)));
         if ($urandom_range(0, 2) == 0)
            write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, CLOCK_W'($urandom));
         repeat (PHASE_BEATS) send_tone(pick_tone(), 1'b0, '0);
      end
      steady = 1'b0;

      req_valid <= 1'b0;
      waited = 0;
      while (pending_settings.size() != 0 && waited < 20000) begin
         @(negedge clock);
         waited++;
      end
      repeat (150) @(negedge clock);
      if (pending_settings.size() != 0)
         report_failure($sformatf("%0d settings never arrived", pending_settings.size()));

      if (mismatch_count == 0)
         $display("tb_pwm_tone_divider_wrap_calc OK");
      else
         $display("tb_pwm_tone_divider_wrap_calc NOT OK");
      $finish;
   end

endmodule

`default_nettype wire
